/* src/longest_increasing_subsequence_length_assert.svh */
// Assertion macros used by the top-level RTL module.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH

// same-cycle implication
`define LIS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lis_pkg.sv */
package lis_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned LENGTH_W = 9;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      start_new;
    } lis_in_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic                overflow;
    } lis_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } lis_state_t;

endpackage

/* src/lis_tail_mem.sv */
module lis_tail_mem #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [lis_pkg::VALUE_W-1:0]  rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [lis_pkg::VALUE_W-1:0]  wr_data
);

    logic [lis_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [lis_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/lis_search.sv */
module lis_search #(
    parameter int unsigned MAX_TAILS = 256,
    parameter int unsigned CNT_W     = 9,
    parameter int unsigned IDX_W     = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lis_pkg::lis_in_t             in_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output lis_pkg::lis_out_t            res_data,
    output logic                         mem_rd_en,
    output logic [IDX_W-1:0]             mem_rd_addr,
    input  logic [lis_pkg::VALUE_W-1:0]  mem_rd_data,
    output logic                         mem_wr_en,
    output logic [IDX_W-1:0]             mem_wr_addr,
    output logic [lis_pkg::VALUE_W-1:0]  mem_wr_data,
    output logic [CNT_W-1:0]             tail_count,
    output logic                         ovf_seen
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAILS);

    lis_pkg::lis_state_t state_reg, state_next;
    logic signed [lis_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] lo_n, hi_n, mid_n;
    logic             tail_less;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lis_pkg::ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

    always_comb begin
        state_next  = state_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = mid_reg[IDX_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = lo_reg[IDX_W-1:0];
        mem_wr_data = key_reg;
        cnt_base    = count_reg;
        tail_less   = $signed(mem_rd_data) < key_reg;
        lo_n        = lo_reg;
        hi_n        = hi_reg;
        mid_n       = mid_reg;
        res_data.length   = lis_pkg::LENGTH_W'(count_reg);
        res_data.overflow = ovf_reg;

        unique case (state_reg)
            lis_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next = in_data.value;
                    if (in_data.start_new) begin
                        cnt_base   = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    lo_next = '0;
                    hi_next = cnt_base;
                    if (cnt_base != '0) begin
                        mid_n       = cnt_base >> 1;
                        mid_next    = mid_n;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = mid_n[IDX_W-1:0];
                        state_next  = lis_pkg::ST_SEARCH;
                    end else begin
                        state_next = lis_pkg::ST_UPDATE;
                    end
                end
            end
            lis_pkg::ST_SEARCH: begin
                // read data belongs to mid_reg; next probe issued in the same cycle
                if (tail_less) begin
                    lo_n = mid_reg + 1'b1;
                end else begin
                    hi_n = mid_reg;
                end
                lo_next = lo_n;
                hi_next = hi_n;
                if (lo_n < hi_n) begin
                    mid_n       = lo_n + ((hi_n - lo_n) >> 1);
                    mid_next    = mid_n;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_n[IDX_W-1:0];
                end else begin
                    state_next = lis_pkg::ST_UPDATE;
                end
            end
            lis_pkg::ST_UPDATE: begin
                res_valid = 1'b1;
                // lo_reg equals count_reg when no tail is >= key
                if (lo_reg < count_reg) begin
                    mem_wr_en = res_ready;
                end else if (count_reg < MAX_CNT) begin
                    mem_wr_en  = res_ready;
                    count_next = res_ready ? count_reg + 1'b1 : count_reg;
                    res_data.length = lis_pkg::LENGTH_W'(count_reg + 1'b1);
                end else begin
                    ovf_next = res_ready ? 1'b1 : ovf_reg;
                    res_data.overflow = 1'b1;
                end
                if (res_ready) begin
                    state_next = lis_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lis_pkg::ST_IDLE;
            end
        endcase
    end

    assign tail_count = count_reg;
    assign ovf_seen   = ovf_reg;

endmodule

/* src/longest_increasing_subsequence_length.sv */
// Channel  | Ports                           | Carries
// ---------+---------------------------------+--------------------------------
// input    | s_valid, s_ready, s_payload     | value, start_new
// result   | m_valid, m_ready, m_payload     | length, overflow
//
// One item at a time: an accept state, one binary-search probe of the tail RAM per
// search step (at most ceil(log2(count+1)) probes, 9 at 256 tails), an update/write state.
// Search speed is set by the single read port of the RAM (registered read).
// Reset (aresetn, sync, active low) clears count and overflow; RAM is not cleared.
// A full output register stalls the block in its update cycle until m_ready.
module longest_increasing_subsequence_length #(
    parameter int unsigned MAX_TAILS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lis_pkg::lis_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output lis_pkg::lis_out_t m_payload
);

    `include "longest_increasing_subsequence_length_assert.svh"

    localparam int unsigned CNT_W = $clog2(MAX_TAILS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_TAILS);

    logic                        res_valid;
    logic                        res_ready;
    lis_pkg::lis_out_t           res_data;
    logic                        mem_rd_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    logic [lis_pkg::VALUE_W-1:0] mem_rd_data;
    logic                        mem_wr_en;
    logic [IDX_W-1:0]            mem_wr_addr;
    logic [lis_pkg::VALUE_W-1:0] mem_wr_data;
    logic [CNT_W-1:0]            tail_count;
    logic                        ovf_seen;

    logic              m_valid_reg;
    lis_pkg::lis_out_t m_payload_reg;

    lis_search #(
        .MAX_TAILS (MAX_TAILS),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_payload),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .tail_count  (tail_count),
        .ovf_seen    (ovf_seen)
    );

    lis_tail_mem #(
        .DEPTH  (MAX_TAILS),
        .ADDR_W (IDX_W)
    ) u_tail_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_payload_reg <= res_data;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `LIS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while previous transaction still in flight")
    `LIS_ASSERT_NEXT(a_start_clears, aclk, aresetn, s_valid && s_ready && s_payload.start_new, (tail_count == '0) && !ovf_seen, "start_new did not clear tail count and overflow")
    `LIS_ASSERT_NOW(a_ovf_only_when_full, aclk, aresetn, res_valid && res_data.overflow && !ovf_seen, tail_count == CNT_W'(MAX_TAILS), "overflow raised while tail store not full")

endmodule

/* tb/longest_increasing_subsequence_length_test.sv */
module longest_increasing_subsequence_length_test;

    localparam int unsigned MAX_TAILS   = 256;
    localparam int unsigned ITEM_GOAL   = 1850;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN       = 40;

    typedef enum int {
        SEQ_NOISE,
        SEQ_WIDE,
        SEQ_NARROW,
        SEQ_RISING,
        SEQ_EXTREME,
        SEQ_FILL
    } seq_kind_t;

    // Tracks the tail store and queues the length/overflow each accepted value should yield.
    class lis_length_board;
        logic signed [lis_pkg::VALUE_W-1:0] tails [MAX_TAILS];
        int unsigned                        tail_count;
        bit                                 full_seen;
        lis_pkg::lis_out_t                  pending [$];
        int unsigned                        errors;
        int unsigned                        dropped_appends;
        int unsigned                        restarts;
        int unsigned                        peak_length;

        function void note_input(lis_pkg::lis_in_t item);
            logic signed [lis_pkg::VALUE_W-1:0] v;
            int unsigned                        pos;
            lis_pkg::lis_out_t                  want;
            v = item.value;
            if (item.start_new) begin
                tail_count = 0;
                full_seen  = 1'b0;
                restarts++;
            end
            pos = 0;
            while (pos < tail_count && tails[pos] < v)
                pos++;
            if (pos < tail_count) begin
                tails[pos] = v;
            end else if (tail_count < MAX_TAILS) begin
                tails[tail_count] = v;
                tail_count++;
            end else begin
                full_seen = 1'b1;
                dropped_appends++;
            end
            if (tail_count > peak_length)
                peak_length = tail_count;
            want.length   = tail_count[lis_pkg::LENGTH_W-1:0];
            want.overflow = full_seen;
            pending = {pending, want};
        endfunction

        function void check_result(lis_pkg::lis_out_t got);
            lis_pkg::lis_out_t want;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: length %0d overflow %0d",
                       got.length, got.overflow);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, got.length);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    lis_pkg::lis_in_t   s_payload;
    logic               m_valid;
    logic               m_ready;
    lis_pkg::lis_out_t  m_payload;

    lis_length_board board;
    int unsigned     items_sent;
    int unsigned     results_seen;
    int unsigned     send_idle_pct;
    int unsigned     quiet_cycles;

    longest_increasing_subsequence_length #(
        .MAX_TAILS(MAX_TAILS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic lis_pkg::lis_in_t make_item(logic signed [lis_pkg::VALUE_W-1:0] v,
                                                   bit first);
        lis_pkg::lis_in_t r;
        r.value     = v;
        r.start_new = first;
        return r;
    endfunction

    task automatic send_item(input lis_pkg::lis_in_t item);
        s_payload <= item;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_input(item);
        items_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    task automatic send_sequence(input seq_kind_t kind);
        logic signed [lis_pkg::VALUE_W-1:0] extremes [7];
        logic signed [lis_pkg::VALUE_W-1:0] v;
        int unsigned                        n;
        extremes = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1,
                     32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
        case (kind)
            SEQ_NOISE: begin
                n = $urandom_range(1, 30);
                repeat (n) send_item(make_item($urandom, 1'($urandom_range(0, 1))));
            end
            SEQ_WIDE: begin
                n = $urandom_range(1, 40);
                send_item(make_item($urandom, 1'b1));
                repeat (n) send_item(make_item($urandom, 1'b0));
            end
            SEQ_NARROW: begin
                // lots of equal values
                n = $urandom_range(1, 40);
                send_item(make_item($signed($urandom_range(0, 8)) - 4, 1'b1));
                repeat (n) send_item(make_item($signed($urandom_range(0, 8)) - 4, 1'b0));
            end
            SEQ_RISING: begin
                n = $urandom_range(1, 60);
                v = $signed($urandom_range(0, 2000000)) - 1000000;
                send_item(make_item(v, 1'b1));
                repeat (n) begin
                    if ($urandom_range(0, 99) < 15)
                        v = v - $signed($urandom_range(0, 2000));
                    else
                        v = v + $signed($urandom_range(1, 1000));
                    send_item(make_item(v, 1'b0));
                end
            end
            SEQ_EXTREME: begin
                n = $urandom_range(1, 20);
                send_item(make_item(extremes[$urandom_range(0, 6)], 1'b1));
                repeat (n) send_item(make_item(extremes[$urandom_range(0, 6)], 1'b0));
            end
            SEQ_FILL: begin
                // strictly rising past the store size, then a few stragglers
                n = MAX_TAILS + $urandom_range(1, 6);
                v = 32'sh8000_0000 + $signed($urandom_range(0, 1000000000));
                send_item(make_item(v, 1'b1));
                repeat (n - 1) begin
                    v = v + $signed($urandom_range(1, 10000000));
                    send_item(make_item(v, 1'b0));
                end
                repeat ($urandom_range(1, 4)) send_item(make_item($urandom, 1'b0));
            end
            default: ;
        endcase
    endtask

    // receiver: random backpressure plus one long hold while the sender keeps going
    initial begin : result_side
        int unsigned hold_left;
        int unsigned ready_pct;
        int unsigned cyc;
        bit          long_hold_done;
        m_ready        = 1'b0;
        hold_left      = 0;
        ready_pct      = 100;
        cyc            = 0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_valid && m_ready) begin
                board.check_result(m_payload);
                results_seen++;
            end
            if (!long_hold_done && results_seen >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (cyc % 128 == 0)
                    case ($urandom_range(0, 2))
                        0:       ready_pct = 100;
                        1:       ready_pct = 70;
                        default: ready_pct = 30;
                    endcase
                if (hold_left > 0) begin
                    hold_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 99) < ready_pct) begin
                    m_ready <= 1'b1;
                end else begin
                    hold_left = pick_gap() - 1;
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        lis_pkg::lis_in_t directed [$];
        seq_kind_t        kind;
        int unsigned      seq_no;
        board         = new();
        items_sent    = 0;
        results_seen  = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        seq_no        = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;

        // first item carries no start flag; equal values; extremes; falling runs
        directed = '{
            make_item(32'sd5, 1'b0),          make_item(32'sd5, 1'b0),
            make_item(32'sd6, 1'b0),          make_item(32'sd6, 1'b0),
            make_item(32'sh7FFF_FFFF, 1'b1),  make_item(32'sh8000_0000, 1'b0),
            make_item(-32'sd1, 1'b0),         make_item(32'sd0, 1'b0),
            make_item(32'sd1, 1'b0),          make_item(32'sh7FFF_FFFF, 1'b0),
            make_item(32'sh7FFF_FFFF, 1'b0),  make_item(32'sh8000_0000, 1'b0),
            make_item(32'sh8000_0000, 1'b1),  make_item(32'sh8000_0000, 1'b0),
            make_item(32'sh7FFF_FFFF, 1'b0),  make_item(32'sh8000_0001, 1'b0),
            make_item(32'sd0, 1'b1),          make_item(-32'sd5, 1'b0),
            make_item(-32'sd10, 1'b0),        make_item(-32'sd3, 1'b0),
            make_item(32'sd100, 1'b0),        make_item(-32'sd1, 1'b1),
            make_item(32'sd7, 1'b1)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_item(directed[i]);

        while (items_sent < ITEM_GOAL) begin
            seq_no++;
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 20;
                default: send_idle_pct = 60;
            endcase
            if (seq_no == 3 || seq_no == 25)
                kind = SEQ_FILL;
            else if ($urandom_range(0, 99) < 2)
                kind = SEQ_FILL;
            else
                kind = seq_kind_t'($urandom_range(SEQ_NOISE, SEQ_EXTREME));
            send_sequence(kind);
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Sent %0d values in %0d sequences; checked %0d results, peak length %0d,",
                 items_sent, seq_no, results_seen, board.peak_length);
        $display("%0d restarts and %0d appends dropped on a full store.",
                 board.restarts, board.dropped_appends);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
